/* rtl/core/mbr_pkg.sv */
// mbr_pkg: shared types and constants for the mipmap box reducer
// no dependencies
package mbr_pkg;
  localparam int MipLevels = 6;
  localparam int MaxDim = 4096;
  localparam int LvlW = 3;
  localparam int PosW = 12;
  localparam int DimW = 13;
  localparam int AddrW = 12;

  localparam logic [1:0] CFG_WIDTH = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_LIN = 2'd2;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pix_t;

  typedef struct packed {
    logic [7:0] amin;
    logic [8:0] bs;
    logic [8:0] gs;
    logic [8:0] rs;
  } pair_t;

  // request handed from one level cell to the next
  typedef struct packed {
    logic vld;
    pix_t pix;
  } lreq_t;

  // result of one level cell
  typedef struct packed {
    logic vld;
    logic [LvlW-1:0] lvl;
    logic [PosW-1:0] col;
    logic [PosW-1:0] row;
    pix_t pix;
    logic last;
  } res_t;

  function automatic logic [AddrW-1:0] store_base(input int lvl);
    int b;
    b = 0;
    for (int k = 0; k < lvl; k++) b = b + (MaxDim >> (k + 1));
    return b[AddrW-1:0];
  endfunction

  function automatic logic [7:0] lin8(input logic [7:0] v);
    logic [15:0] sq;
    sq = v * v;
    return sq[15:8];
  endfunction
endpackage

/* rtl/core/mbr_if.sv */
// mbr_if: valid/ready channel interfaces for pixels and results
// no dependencies
interface mbr_pix_if (input logic clk);
  logic valid;
  logic ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface mbr_res_if (input logic clk);
  logic valid;
  logic ready;
  logic [2:0] level;
  logic [11:0] col;
  logic [11:0] row;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic last;
  modport source (output valid, level, col, row, out_red, out_green, out_blue,
                  out_alpha, last, input ready);
  modport sink (input valid, level, col, row, out_red, out_green, out_blue,
                out_alpha, last, output ready);
endinterface

/* rtl/core/mbr_cell.sv */
// mbr_cell: one mip level; keeps position, held pixel and its pair line block
// depends on mbr_pkg
module mbr_cell (
  input  logic clk,
  input  logic rst_n,
  input  logic [mbr_pkg::LvlW-1:0] lvl_id,
  input  logic [mbr_pkg::AddrW-1:0] base,
  input  logic [mbr_pkg::DimW-1:0] w,
  input  logic [mbr_pkg::DimW-1:0] h,
  input  logic clr,
  input  logic adv,
  input  mbr_pkg::lreq_t req_i,
  output mbr_pkg::lreq_t req_o,
  output mbr_pkg::res_t res_o
);
  logic [mbr_pkg::PosW-1:0] col_r, row_r;
  mbr_pkg::pix_t held_r;
  mbr_pkg::pair_t mem [mbr_pkg::MaxDim];
  mbr_pkg::pair_t rd_r;
  mbr_pkg::lreq_t req_r;
  mbr_pkg::res_t res_r;
  mbr_pkg::pix_t p;
  logic [mbr_pkg::DimW-1:0] wn, hn;
  logic part;
  logic [mbr_pkg::AddrW-1:0] idx;
  mbr_pkg::pair_t q;
  logic [9:0] sr, sg, sb;
  logic [7:0] amin;

  assign p = req_i.pix;
  assign wn = w >> 1;
  assign hn = h >> 1;
  assign part = (lvl_id != mbr_pkg::LvlW'(mbr_pkg::MipLevels - 1)) && wn != '0 && hn != '0
      && {1'b0, col_r} < {wn[mbr_pkg::DimW-2:0], 1'b0}
      && {1'b0, row_r} < {hn[mbr_pkg::DimW-2:0], 1'b0};
  assign idx = base + mbr_pkg::AddrW'(col_r >> 1);

  always_comb begin
    q.rs = {1'b0, held_r.r} + {1'b0, p.r};
    q.gs = {1'b0, held_r.g} + {1'b0, p.g};
    q.bs = {1'b0, held_r.b} + {1'b0, p.b};
    q.amin = (held_r.a < p.a) ? held_r.a : p.a;
    sr = {1'b0, rd_r.rs} + {1'b0, q.rs};
    sg = {1'b0, rd_r.gs} + {1'b0, q.gs};
    sb = {1'b0, rd_r.bs} + {1'b0, q.bs};
    amin = (rd_r.amin < q.amin) ? rd_r.amin : q.amin;
  end

  // line store read at the even pixel so data is registered by the odd pixel
  always_ff @(posedge clk) begin
    if (adv && req_i.vld && part && col_r[0] && !row_r[0]) mem[idx] <= q;
    if (adv && req_i.vld && part && !col_r[0]) held_r <= p;
    if (adv && req_i.vld && part && !col_r[0]) rd_r <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      col_r <= '0;
      row_r <= '0;
      req_r.vld <= 1'b0;
      res_r.vld <= 1'b0;
    end else if (adv) begin
      req_r.vld <= req_i.vld && part && col_r[0] && row_r[0];
      req_r.pix <= '{a: amin, b: sb[9:2], g: sg[9:2], r: sr[9:2]};
      res_r.vld <= req_i.vld;
      res_r.lvl <= lvl_id;
      res_r.col <= col_r;
      res_r.row <= row_r;
      res_r.pix <= p;
      res_r.last <= !(part && col_r[0] && row_r[0]);
      if (req_i.vld) begin
        if ({1'b0, col_r} + 1'b1 >= w) begin
          col_r <= '0;
          row_r <= ({1'b0, row_r} + 1'b1 >= h) ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  assign req_o = req_r;
  assign res_o = res_r;
endmodule

/* rtl/core/mipmap_box_reducer.sv */
// mipmap_box_reducer: streaming 2x2 box filter mip chain, one cell per level
// a level 0 result passes the cell register, the alignment delay and the result queue;
// deeper levels of the same pixel follow at one result per cycle while out_ch is ready
// throughput: one pixel per cycle while the queue has room; results leave one per
// cycle, so at about 1.33 results per pixel the output port sets the rate
// reset: synchronous rst_n clears positions, valids, queue pointers and config; line store is not cleared
module mipmap_box_reducer (
  input  logic clk,
  input  logic rst_n,
  mbr_pix_if.sink in_ch,
  mbr_res_if.source out_ch,
  input  logic cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [12:0] cfg_data
);
  localparam int N = mbr_pkg::MipLevels;
  logic [mbr_pkg::DimW-1:0] w_r, h_r;
  logic lin_r;
  logic [mbr_pkg::DimW-1:0] cw;
  mbr_pkg::lreq_t chain [N+1];
  mbr_pkg::res_t res [N];
  // results of one pixel lined up in the same cycle
  mbr_pkg::res_t al [N];
  // queue of results, deep enough for every pixel in flight
  localparam int QD = 32;
  mbr_pkg::res_t q_r [QD];
  logic [4:0] wp_r, rp_r;
  logic [5:0] cnt_r;
  logic adv;
  logic [2:0] nres;

  // clamp of zero and oversize dimensions
  always_comb begin
    cw = cfg_data;
    if (cw == '0) cw = 13'd1;
    else if (cw > 13'(mbr_pkg::MaxDim)) cw = 13'(mbr_pkg::MaxDim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= 13'(mbr_pkg::MaxDim);
      h_r <= 13'(mbr_pkg::MaxDim);
      lin_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        mbr_pkg::CFG_WIDTH: w_r <= cw;
        mbr_pkg::CFG_HEIGHT: h_r <= cw;
        mbr_pkg::CFG_LIN: lin_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline advances only when the queue has room for a full worst case
  assign adv = cnt_r <= 6'(QD - 2 * N);
  assign in_ch.ready = adv;

  always_comb begin
    chain[0].vld = in_ch.valid;
    chain[0].pix.a = in_ch.alpha;
    chain[0].pix.r = lin_r ? mbr_pkg::lin8(in_ch.red) : in_ch.red;
    chain[0].pix.g = lin_r ? mbr_pkg::lin8(in_ch.green) : in_ch.green;
    chain[0].pix.b = lin_r ? mbr_pkg::lin8(in_ch.blue) : in_ch.blue;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    mbr_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .lvl_id(3'(i)), .base(mbr_pkg::store_base(i + 1)),
      .w(w_r >> i), .h(h_r >> i),
      .clr(cfg_we && (cfg_idx == mbr_pkg::CFG_WIDTH || cfg_idx == mbr_pkg::CFG_HEIGHT
          || cfg_idx == mbr_pkg::CFG_LIN)),
      .adv(adv),
      .req_i(chain[i]), .req_o(chain[i+1]), .res_o(res[i])
    );
  end

  // level i result of a pixel appears i steps after level 0, so delay it by
  // the remaining steps; then one cycle holds every result of one pixel
  for (genvar i = 0; i < N; i++) begin : g_align
    if (i == N - 1) begin : g_direct
      assign al[i] = res[i];
    end else begin : g_delay
      mbr_pkg::res_t dl_r [N-1-i];
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          for (int j = 0; j < N - 1 - i; j++) dl_r[j].vld <= 1'b0;
        end else if (adv) begin
          dl_r[0] <= res[i];
          for (int j = 1; j < N - 1 - i; j++) dl_r[j] <= dl_r[j-1];
        end
      end
      assign al[i] = dl_r[N-2-i];
    end
  end

  // all results pushed in one cycle belong to one pixel, so push them
  // in level order
  always_comb begin
    nres = '0;
    for (int i = 0; i < N; i++) nres = nres + 3'(al[i].vld && adv);
  end

  always_ff @(posedge clk) begin
    logic [4:0] p;
    p = wp_r;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (al[i].vld && adv) begin
          q_r[p] <= al[i];
          p = p + 1'b1;
        end
      end
      wp_r <= p;
      if (out_ch.valid && out_ch.ready) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 6'(nres) - 6'(out_ch.valid && out_ch.ready);
    end
  end

  assign out_ch.valid = cnt_r != '0;
  assign out_ch.level = q_r[rp_r].lvl;
  assign out_ch.col = q_r[rp_r].col;
  assign out_ch.row = q_r[rp_r].row;
  assign out_ch.out_red = q_r[rp_r].pix.r;
  assign out_ch.out_green = q_r[rp_r].pix.g;
  assign out_ch.out_blue = q_r[rp_r].pix.b;
  assign out_ch.out_alpha = q_r[rp_r].pix.a;
  assign out_ch.last = q_r[rp_r].last;

  property p_cnt;
    @(posedge clk) disable iff (!rst_n) cnt_r <= 6'(QD);
  endproperty
  a_cnt: assert property (p_cnt) else $error("result queue overflow");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
      (cnt_r == '0) |-> !out_ch.valid) else $error("valid with empty queue");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      (out_ch.valid && !out_ch.ready) |=> (out_ch.valid
      && $stable({out_ch.level, out_ch.col, out_ch.row, out_ch.last})))
      else $error("waiting request changed");
endmodule
